@@ rtl/indexed_max_heap_queue_top_macros.svh @@
// Assertion macros used by the indexed max-heap queue datapath.
`ifndef INDEXED_MAX_HEAP_QUEUE_TOP_MACROS_SVH
`define INDEXED_MAX_HEAP_QUEUE_TOP_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define IMH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true.
`define IMH_NEVER(lbl, cond, msg) `IMH_ASSERT(lbl, !(cond), msg)

`endif

@@ rtl/imh_pkg.sv @@
// Types, codes and controller/datapath command structs for the heap queue.
`default_nettype none
package imh_pkg;

  typedef struct packed {
    logic [1:0]  command;
    logic [9:0]  item_id;
    logic [30:0] new_key;
  } imh_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  removed_id;
    logic [30:0] removed_key;
    logic        was_present;
    logic [10:0] queue_count;
  } imh_out_t;

  localparam logic [1:0] CMD_INSERT   = 2'd0;
  localparam logic [1:0] CMD_INCREASE = 2'd1;
  localparam logic [1:0] CMD_DELETE   = 2'd2;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_PRESENT    = 3'd1;
  localparam logic [2:0] ST_ABSENT     = 3'd2;
  localparam logic [2:0] ST_NOT_RAISED = 3'd3;
  localparam logic [2:0] ST_EMPTY      = 3'd4;
  localparam logic [2:0] ST_FULL       = 3'd5;

  // heap memory read address select
  typedef enum logic [2:0] {
    HR_NONE, HR_ROOT, HR_LAST, HR_PARENT, HR_LEFT, HR_RIGHT
  } heap_rd_e;

  // key memory read address select
  typedef enum logic [1:0] {
    KR_NONE, KR_ID, KR_HEAP
  } key_rd_e;

  // heap / position map write select
  typedef enum logic [2:0] {
    WR_NONE, WR_CLR, WR_UP, WR_DN, WR_PLACE, WR_ZERO
  } wr_e;

  // datapath register loads
  typedef enum logic [3:0] {
    RG_NONE, RG_LOAD, RG_INS, RG_INC, RG_DEL_A, RG_DEL_B, RG_DEL_C, RG_DN_L, RG_DN_R
  } reg_e;

  typedef struct packed {
    heap_rd_e   hrd;
    key_rd_e    krd;
    logic       pos_rd;
    wr_e        wr;
    logic       key_wr;
    reg_e       rop;
    logic       st_set;
    logic [2:0] st;
    logic       ld_out;
  } imh_cmd_t;

  typedef struct packed {
    logic [1:0] command;
    logic       in_range;
    logic       present;
    logic       key_gt;
    logic       cnt_zero;
    logic       cnt_full;
    logic       at_root;
    logic       has_child;
    logic       has_right;
    logic       go_up;
    logic       go_dn;
    logic       clr_last;
    logic       out_free;
  } imh_stat_t;

endpackage
`default_nettype wire

@@ rtl/imh_dp.sv @@
// Datapath: heap, position map and key memories, working registers, output word.
`default_nettype none
`include "indexed_max_heap_queue_top_macros.svh"
module imh_dp
  import imh_pkg::*;
#(
  parameter int CAPACITY = 1024,
  parameter int KEY_BITS = 31
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire imh_in_t   in_data_i,
  input  wire imh_cmd_t  cmd_i,
  output imh_stat_t      stat_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output imh_out_t       out_data_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int SW = $clog2(CAPACITY + 1);
  localparam int KW = KEY_BITS;

  logic [AW-1:0] heap_mem [CAPACITY];
  logic [SW-1:0] pos_mem  [CAPACITY];
  logic [KW-1:0] key_mem  [CAPACITY];

  logic [AW-1:0] heap_rd_q;
  logic [SW-1:0] pos_rd_q;
  logic [KW-1:0] key_rd_q;

  logic [1:0]    cmd_q;
  logic [9:0]    id_q;
  logic [KW-1:0] key_q;
  logic [SW-1:0] cnt_q;
  logic [SW-1:0] slot_q;
  logic [AW-1:0] cur_id_q, top_id_q, lid_q;
  logic [KW-1:0] cur_key_q, top_key_q, lkey_q;
  logic [2:0]    st_q;
  logic [AW-1:0] clr_q;
  logic          out_valid_q;
  imh_out_t      out_q;

  logic [AW+9:0] id_wide;
  logic [AW-1:0] id_idx;
  logic          in_range;
  logic [SW:0]   slot2, cnt_x, lft_w;
  logic [SW-1:0] slot_m1, cnt_m1, parent, par_m1, ch_slot;
  logic          chose_right;
  logic [AW-1:0] ch_id;
  logic [KW-1:0] ch_key;
  logic [KW+30:0] nk_w, tk_w;
  logic [AW+9:0] tid_w;
  logic [SW+10:0] cnt_w;
  logic          del_ok;

  logic          heap_re;
  logic [AW-1:0] heap_ra;
  logic          key_re;
  logic [AW-1:0] key_ra;
  logic          heap_we;
  logic [AW-1:0] heap_wa, heap_wd;
  logic          pos_we;
  logic [AW-1:0] pos_wa;
  logic [SW-1:0] pos_wd;

  assign id_wide  = {{AW{1'b0}}, id_q};
  assign id_idx   = id_wide[AW-1:0];
  assign in_range = id_wide < (AW+10)'(CAPACITY);

  assign slot2   = {slot_q, 1'b0};
  assign cnt_x   = {1'b0, cnt_q};
  assign lft_w   = slot2 - 1'b1;
  assign slot_m1 = slot_q - 1'b1;
  assign cnt_m1  = cnt_q - 1'b1;
  assign parent  = slot_q >> 1;
  assign par_m1  = parent - 1'b1;

  assign chose_right = (slot2 < cnt_x) && (lkey_q < key_rd_q);
  assign ch_id   = chose_right ? heap_rd_q : lid_q;
  assign ch_key  = chose_right ? key_rd_q : lkey_q;
  assign ch_slot = {slot_q[SW-2:0], chose_right};

  assign nk_w  = {{KW{1'b0}}, in_data_i.new_key};
  assign tk_w  = {31'b0, top_key_q};
  assign tid_w = {10'b0, top_id_q};
  assign cnt_w = {11'b0, cnt_q};
  assign del_ok = (cmd_q == CMD_DELETE) && (st_q == ST_OK);

  always_comb begin
    stat_o.command   = cmd_q;
    stat_o.in_range  = in_range;
    stat_o.present   = in_range && (pos_rd_q != '0);
    stat_o.key_gt    = key_q > key_rd_q;
    stat_o.cnt_zero  = cnt_q == '0;
    stat_o.cnt_full  = cnt_q == SW'(CAPACITY);
    stat_o.at_root   = slot_q == SW'(1);
    stat_o.has_child = slot2 <= cnt_x;
    stat_o.has_right = slot2 < cnt_x;
    stat_o.go_up     = key_rd_q < cur_key_q;
    stat_o.go_dn     = cur_key_q < ch_key;
    stat_o.clr_last  = clr_q == AW'(CAPACITY - 1);
    stat_o.out_free  = !out_valid_q || out_ready_i;
  end

  always_comb begin
    heap_re = cmd_i.hrd != HR_NONE;
    case (cmd_i.hrd)
      HR_LAST:   heap_ra = cnt_m1[AW-1:0];
      HR_PARENT: heap_ra = par_m1[AW-1:0];
      HR_LEFT:   heap_ra = lft_w[AW-1:0];
      HR_RIGHT:  heap_ra = slot2[AW-1:0];
      default:   heap_ra = '0;
    endcase
    key_re = cmd_i.krd != KR_NONE;
    key_ra = (cmd_i.krd == KR_HEAP) ? heap_rd_q : id_idx;

    heap_we = 1'b0;
    heap_wa = slot_m1[AW-1:0];
    heap_wd = cur_id_q;
    pos_we  = 1'b1;
    pos_wa  = cur_id_q;
    pos_wd  = slot_q;
    unique case (cmd_i.wr)
      WR_CLR: begin
        pos_wa = clr_q;
        pos_wd = '0;
      end
      WR_UP: begin
        heap_we = 1'b1;
        heap_wd = heap_rd_q;
        pos_wa  = heap_rd_q;
      end
      WR_DN: begin
        heap_we = 1'b1;
        heap_wd = ch_id;
        pos_wa  = ch_id;
      end
      WR_PLACE: heap_we = 1'b1;
      WR_ZERO: begin
        pos_wa = top_id_q;
        pos_wd = '0;
      end
      default: pos_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (heap_we) heap_mem[heap_wa] <= heap_wd;
    if (heap_re) heap_rd_q <= heap_mem[heap_ra];
  end

  always_ff @(posedge clk_i) begin
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    if (cmd_i.pos_rd) pos_rd_q <= pos_mem[id_idx];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_wr) key_mem[id_idx] <= key_q;
    if (key_re) key_rd_q <= key_mem[key_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.rop == RG_INS) cnt_q <= cnt_q + 1'b1;
      else if (cmd_i.rop == RG_DEL_B) cnt_q <= cnt_m1;
      if (cmd_i.wr == WR_CLR) clr_q <= clr_q + 1'b1;
      if (cmd_i.ld_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.rop)
      RG_LOAD: begin
        cmd_q <= in_data_i.command;
        id_q  <= in_data_i.item_id;
        key_q <= nk_w[KW-1:0];
      end
      RG_INS: begin
        slot_q    <= cnt_q + 1'b1;
        cur_id_q  <= id_idx;
        cur_key_q <= key_q;
      end
      RG_INC: begin
        slot_q    <= pos_rd_q;
        cur_id_q  <= id_idx;
        cur_key_q <= key_q;
      end
      RG_DEL_A: top_id_q <= heap_rd_q;
      RG_DEL_B: begin
        top_key_q <= key_rd_q;
        cur_id_q  <= heap_rd_q;
        slot_q    <= SW'(1);
      end
      RG_DEL_C: cur_key_q <= key_rd_q;
      RG_DN_L:  lid_q <= heap_rd_q;
      RG_DN_R:  lkey_q <= key_rd_q;
      default: ;
    endcase
    if (cmd_i.wr == WR_UP) slot_q <= parent;
    else if (cmd_i.wr == WR_DN) slot_q <= ch_slot;
    if (cmd_i.st_set) st_q <= cmd_i.st;
    if (cmd_i.ld_out) begin
      out_q.status      <= st_q;
      out_q.removed_id  <= del_ok ? tid_w[9:0] : 10'd0;
      out_q.removed_key <= del_ok ? tk_w[30:0] : 31'd0;
      out_q.was_present <= in_range && (pos_rd_q != '0);
      out_q.queue_count <= cnt_w[10:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `IMH_ASSERT(a_cnt_bound, cnt_q <= SW'(CAPACITY), "heap count above capacity")
  `IMH_ASSERT(a_cnt_step, (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + 1'b1) || (cnt_q == $past(cnt_q) - 1'b1), "heap count jumped")
  `IMH_NEVER(a_no_overwrite, cmd_i.ld_out && out_valid_q && !out_ready_i, "result word overwritten")
  `IMH_ASSERT(a_place_range, (cmd_i.wr == WR_PLACE) |-> ((slot_q != '0) && ((slot_q <= cnt_q) || (slot_q == SW'(1)))), "placement slot outside heap")

endmodule
`default_nettype wire

@@ rtl/imh_ctrl.sv @@
// Controller: sequences the position-map clear after reset, lookup, sift-up, sift-down and result hand-off.
`default_nettype none
module imh_ctrl
  import imh_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire imh_stat_t stat_i,
  output imh_cmd_t       cmd_o
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_LOOK, S_DECIDE, S_DEL_B, S_DEL_C,
    S_UP_CHK, S_UP_RDK, S_UP_CMP, S_UP_PLACE,
    S_DN_CHK, S_DN_RL, S_DN_RR, S_DN_CMP, S_DN_PLACE, S_DN_CLR, S_FIN
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.hrd     = HR_NONE;
    cmd_o.krd     = KR_NONE;
    cmd_o.wr      = WR_NONE;
    cmd_o.rop     = RG_NONE;
    cmd_o.st      = ST_OK;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.wr = WR_CLR;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.rop = RG_LOAD;
          state_d   = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd_o.hrd    = HR_ROOT;
        cmd_o.krd    = KR_ID;
        cmd_o.pos_rd = 1'b1;
        state_d      = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.st_set = 1'b1;
        state_d      = S_FIN;
        unique case (stat_i.command)
          CMD_INSERT: begin
            if (!stat_i.in_range) cmd_o.st = ST_ABSENT;
            else if (stat_i.present) cmd_o.st = ST_PRESENT;
            else if (stat_i.cnt_full) cmd_o.st = ST_FULL;
            else begin
              cmd_o.key_wr = 1'b1;
              cmd_o.rop    = RG_INS;
              state_d      = S_UP_CHK;
            end
          end
          CMD_INCREASE: begin
            if (!stat_i.present) cmd_o.st = ST_ABSENT;
            else if (!stat_i.key_gt) cmd_o.st = ST_NOT_RAISED;
            else begin
              cmd_o.key_wr = 1'b1;
              cmd_o.rop    = RG_INC;
              state_d      = S_UP_CHK;
            end
          end
          CMD_DELETE: begin
            if (stat_i.cnt_zero) cmd_o.st = ST_EMPTY;
            else begin
              cmd_o.hrd = HR_LAST;
              cmd_o.krd = KR_HEAP;
              cmd_o.rop = RG_DEL_A;
              state_d   = S_DEL_B;
            end
          end
          default: ;
        endcase
      end
      S_DEL_B: begin
        cmd_o.krd = KR_HEAP;
        cmd_o.rop = RG_DEL_B;
        state_d   = S_DEL_C;
      end
      S_DEL_C: begin
        cmd_o.rop = RG_DEL_C;
        state_d   = S_DN_CHK;
      end
      S_UP_CHK: begin
        if (stat_i.at_root) state_d = S_UP_PLACE;
        else begin
          cmd_o.hrd = HR_PARENT;
          state_d   = S_UP_RDK;
        end
      end
      S_UP_RDK: begin
        cmd_o.krd = KR_HEAP;
        state_d   = S_UP_CMP;
      end
      S_UP_CMP: begin
        if (stat_i.go_up) begin
          cmd_o.wr = WR_UP;
          state_d  = S_UP_CHK;
        end else begin
          state_d = S_UP_PLACE;
        end
      end
      S_UP_PLACE: begin
        cmd_o.wr = WR_PLACE;
        state_d  = S_FIN;
      end
      S_DN_CHK: begin
        if (stat_i.has_child) begin
          cmd_o.hrd = HR_LEFT;
          state_d   = S_DN_RL;
        end else begin
          state_d = S_DN_PLACE;
        end
      end
      S_DN_RL: begin
        cmd_o.rop = RG_DN_L;
        cmd_o.krd = KR_HEAP;
        if (stat_i.has_right) cmd_o.hrd = HR_RIGHT;
        state_d = S_DN_RR;
      end
      S_DN_RR: begin
        cmd_o.rop = RG_DN_R;
        if (stat_i.has_right) cmd_o.krd = KR_HEAP;
        state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (stat_i.go_dn) begin
          cmd_o.wr = WR_DN;
          state_d  = S_DN_CHK;
        end else begin
          state_d = S_DN_PLACE;
        end
      end
      S_DN_PLACE: begin
        cmd_o.wr = WR_PLACE;
        state_d  = S_DN_CLR;
      end
      S_DN_CLR: begin
        // removed id leaves the position map last
        cmd_o.wr = WR_ZERO;
        state_d  = S_FIN;
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.ld_out = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/indexed_max_heap_queue_top.sv @@
// Top level of the indexed binary max-heap priority queue.
// Input word: command (insert, increase key, delete max), item_id, new_key,
// taken on in_valid_i & in_ready_o. Output word: status, removed id/key,
// was_present and queue_count, offered on out_valid_o until out_ready_i.
// One command is worked on at a time; ready is high only while idle.
// A command walks L heap levels (at most log2(CAPACITY)); steps per level:
//   insert / increase key: parent id read, key read, move
//   delete maximum:        left id, left key and right id,
//                          right key, move
//   rejected commands:     no level walk; the result follows the lookup
// The steps come from the heap and key memories, each with a single read
// port, so the reads of one level step follow one another.
// After reset the position map is cleared, one entry a cycle, all
// CAPACITY entries, with in_ready_o low. A finished word waits in the output
// register; the next command is accepted meanwhile and, if its result is
// ready before the receiver takes the old word, it waits in its last state.
`default_nettype none
module indexed_max_heap_queue_top
  import imh_pkg::*;
#(
  parameter int CAPACITY = 1024,
  parameter int KEY_BITS = 31
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire imh_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output imh_out_t     out_data_o
);

  imh_cmd_t  cmd;
  imh_stat_t stat;

  imh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  imh_dp #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
